// ===== rtl/core/fqrd_pkg.sv =====
// Package: shared types and constants of the FASTQ record deframer.
`timescale 1ns / 1ps

package fqrd_pkg;

  // Width of the sequence line counter
  localparam int unsigned LineCountBits = 16;

  // Stream characters
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChPlus    = 8'h2B;

  // Section codes as seen on the result channel
  localparam logic [1:0] SecHeader = 2'd0;
  localparam logic [1:0] SecSeq    = 2'd1;
  localparam logic [1:0] SecSpacer = 2'd2;
  localparam logic [1:0] SecQual   = 2'd3;

  // Status codes
  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StClean = 2'd1;
  localparam logic [1:0] StTrunc = 2'd2;

  // Record parsing phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SEQ    = 4'b0010,
    PH_SPACER = 4'b0100,
    PH_QUAL   = 4'b1000
  } phase_t;

  typedef logic [LineCountBits-1:0] line_cnt_t;

  // Result sideband fields
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] section;
    logic       byte_valid;
  } out_user_t;

  // Section code of a phase
  function automatic logic [1:0] phase_to_sec(input phase_t ph);
    logic [1:0] sec;
    case (ph)
      PH_HEADER: sec = SecHeader;
      PH_SEQ:    sec = SecSeq;
      PH_SPACER: sec = SecSpacer;
      PH_QUAL:   sec = SecQual;
      default:   sec = SecHeader;
    endcase
    return sec;
  endfunction

endpackage

// ===== rtl/core/fastq_record_deframer_unit.sv =====
// The result of an accepted input transaction is on the output in the next cycle.
// Throughput: one transaction per cycle; the single output register refills in the cycle
// it is taken, so in_tready follows out_tready while a result is held.
// Reset (rst_n low, synchronous): phase to header, line count and record flag cleared,
// copy_enable cleared, output register emptied.
// End-of-stream transactions return the parser to its reset state; copy_enable is kept.
`timescale 1ns / 1ps

module fastq_record_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] end_marker
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [4:0] out_tuser,   // [0] out_valid, [2:1] section, [4:3] status
  output logic       out_tlast    // record_end
);

  // Parser state
  fqrd_pkg::phase_t    phase_r, phase_nxt;
  fqrd_pkg::line_cnt_t lines_left_r, lines_left_nxt;
  logic                in_record_r, in_record_nxt;
  logic                copy_en_r;

  // Output register
  logic                 out_vld_r;
  logic [7:0]           out_byte_r, out_byte_nxt;
  fqrd_pkg::out_user_t  out_user_r, out_user_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_fire;
  logic                 is_nl;
  logic                 is_plus;
  fqrd_pkg::line_cnt_t  qual_dec;

  assign in_tready = !out_vld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_nl     = (in_tdata == fqrd_pkg::ChNewline);
  assign is_plus   = (in_tdata == fqrd_pkg::ChPlus);
  assign qual_dec  = (lines_left_r != '0) ? lines_left_r - 1'b1 : '0;

  // Next parser state and result for the current transaction
  always_comb begin
    phase_nxt      = phase_r;
    lines_left_nxt = lines_left_r;
    in_record_nxt  = in_record_r;
    out_byte_nxt   = in_tdata;
    out_last_nxt   = 1'b0;
    out_user_nxt.byte_valid = copy_en_r;
    out_user_nxt.section    = fqrd_pkg::phase_to_sec(phase_r);
    out_user_nxt.status     = fqrd_pkg::StRun;

    if (in_tuser) begin
      // End of stream: report and return to reset state
      out_byte_nxt            = '0;
      out_user_nxt.byte_valid = 1'b0;
      if (!in_record_r ||
          (phase_r == fqrd_pkg::PH_QUAL && lines_left_r <= fqrd_pkg::line_cnt_t'(1))) begin
        out_user_nxt.status = fqrd_pkg::StClean;
      end else begin
        out_user_nxt.status = fqrd_pkg::StTrunc;
      end
      phase_nxt      = fqrd_pkg::PH_HEADER;
      lines_left_nxt = '0;
      in_record_nxt  = 1'b0;
    end else begin
      in_record_nxt = 1'b1;
      case (phase_r)
        fqrd_pkg::PH_HEADER: begin
          if (is_nl) phase_nxt = fqrd_pkg::PH_SEQ;
        end
        fqrd_pkg::PH_SEQ: begin
          if (is_plus) begin
            // '+' ends the sequence wherever it stands; tagged as spacer
            out_user_nxt.section = fqrd_pkg::SecSpacer;
            phase_nxt            = fqrd_pkg::PH_SPACER;
          end else if (is_nl && lines_left_r != '1) begin
            lines_left_nxt = lines_left_r + 1'b1;
          end
        end
        fqrd_pkg::PH_SPACER: begin
          if (is_nl) begin
            if (lines_left_r == '0) begin
              // No sequence lines: spacer newline closes the record
              out_last_nxt   = 1'b1;
              phase_nxt      = fqrd_pkg::PH_HEADER;
              in_record_nxt  = 1'b0;
            end else begin
              phase_nxt = fqrd_pkg::PH_QUAL;
            end
          end
        end
        fqrd_pkg::PH_QUAL: begin
          if (is_nl) begin
            lines_left_nxt = qual_dec;
            if (qual_dec == '0) begin
              out_last_nxt  = 1'b1;
              phase_nxt     = fqrd_pkg::PH_HEADER;
              in_record_nxt = 1'b0;
            end
          end
        end
        default: begin
          phase_nxt = fqrd_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fqrd_pkg::PH_HEADER;
      lines_left_r <= '0;
      in_record_r  <= 1'b0;
      copy_en_r    <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) copy_en_r <= cfg_wdata;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        lines_left_r <= lines_left_nxt;
        in_record_r  <= in_record_nxt;
        out_vld_r    <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r <= out_byte_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/fqrd_checker.sv =====
// Checker: port-level properties of the FASTQ record deframer, and its bind.
`timescale 1ns / 1ps

module fqrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [4:0] out_tuser,
  input logic       out_tlast
);

  // A held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("fqrd: stalled result changed");

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("fqrd: result valid after reset");

  // A record ends only on a newline in spacer or quality, while running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == fqrd_pkg::ChNewline
      && (out_tuser[2:1] == fqrd_pkg::SecSpacer || out_tuser[2:1] == fqrd_pkg::SecQual)
      && out_tuser[4:3] == fqrd_pkg::StRun)
    else $error("fqrd: bad record end");

  // End-of-stream results carry no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:3] != fqrd_pkg::StRun |-> out_tdata == 8'h00 && !out_tuser[0]
      && out_tuser[4:3] != 2'd3)
    else $error("fqrd: end-of-stream result carries data");

endmodule

bind fastq_record_deframer_unit fqrd_checker u_fqrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/fqrd_record_monitor.sv =====
// Record monitor for the FASTQ deframer: tracks record sections, predicts each result, compares.
`timescale 1ns / 1ps

module fqrd_record_monitor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [4:0] out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending,
  output int         bytes_checked,
  output int         records_closed,
  output int         clean_ends,
  output int         trunc_ends
);

  // Expected tagging of one byte transaction
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] section;
    logic       rec_end;
    logic [1:0] status;
  } byte_tag_t;

  byte_tag_t tags_due[$];

  // Parser state as the block should hold it
  logic                copy_en;
  logic [1:0]          sec_now;
  fqrd_pkg::line_cnt_t lines_left;
  logic                in_rec;

  task automatic clear_parser();
    sec_now    = fqrd_pkg::SecHeader;
    lines_left = '0;
    in_rec     = 1'b0;
  endtask

  task automatic mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Advance the section tracker by one transaction and tag it
  task automatic follow_byte(input logic [7:0] b, input logic eos, output byte_tag_t t);
    t         = '0;
    t.section = sec_now;
    t.status  = fqrd_pkg::StRun;
    if (eos) begin
      // clean between records, or with one quality line left open
      t.status = (!in_rec || (sec_now == fqrd_pkg::SecQual && lines_left <= 1)) ?
                 fqrd_pkg::StClean : fqrd_pkg::StTrunc;
      clear_parser();
    end else begin
      in_rec  = 1'b1;
      t.data  = b;
      t.valid = copy_en;
      case (sec_now)
        fqrd_pkg::SecHeader: begin
          if (b == fqrd_pkg::ChNewline) sec_now = fqrd_pkg::SecSeq;
        end
        fqrd_pkg::SecSeq: begin
          if (b == fqrd_pkg::ChPlus) begin
            // plus ends the sequence anywhere, tagged as spacer
            t.section = fqrd_pkg::SecSpacer;
            sec_now   = fqrd_pkg::SecSpacer;
          end else if (b == fqrd_pkg::ChNewline && lines_left != '1) begin
            lines_left++;
          end
        end
        fqrd_pkg::SecSpacer: begin
          if (b == fqrd_pkg::ChNewline) begin
            if (lines_left == '0) begin
              t.rec_end = 1'b1;
              clear_parser();
            end else begin
              sec_now = fqrd_pkg::SecQual;
            end
          end
        end
        default: begin
          if (b == fqrd_pkg::ChNewline) begin
            if (lines_left != '0) lines_left--;
            if (lines_left == '0) begin
              t.rec_end = 1'b1;
              clear_parser();
            end
          end
        end
      endcase
    end
  endtask

  // Results are checked before new input is predicted, as the block registers each result
  always @(posedge clk) begin
    fqrd_pkg::out_user_t user_now;
    byte_tag_t           due;
    if (!rst_n) begin
      tags_due.delete();
      copy_en = 1'b0;
      clear_parser();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        user_now = out_tuser;
        if (tags_due.size() == 0) begin
          fail_count++;
          $error("result transaction with no byte waiting for it");
        end else begin
          due = tags_due.pop_front();
          bytes_checked++;
          mismatch("out_byte", due.data, out_tdata);
          mismatch("out_valid", 8'(due.valid), 8'(user_now.byte_valid));
          mismatch("section", 8'(due.section), 8'(user_now.section));
          mismatch("status", 8'(due.status), 8'(user_now.status));
          mismatch("record_end", 8'(due.rec_end), 8'(out_tlast));
          if (due.rec_end) records_closed++;
          if (due.status == fqrd_pkg::StClean) clean_ends++;
          else if (due.status == fqrd_pkg::StTrunc) trunc_ends++;
        end
      end
      if (in_tvalid && in_tready) begin
        follow_byte(in_tdata, in_tuser, due);
        tags_due.push_back(due);
      end
      if (cfg_we) copy_en = cfg_wdata;
      pending = tags_due.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the FASTQ deframer testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic       cfg_wdata  = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tuser   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  int fail_count;
  int pending;
  int bytes_checked;
  int records_closed;
  int clean_ends;
  int trunc_ends;

  int items_sent  = 0;
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int stall_left  = 0;

  // Record truncation control for the random records
  int cut_left;
  bit cut_done;

  fastq_record_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fqrd_record_monitor mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .bytes_checked  (bytes_checked),
    .records_closed (records_closed),
    .clean_ends     (clean_ends),
    .trunc_ends     (trunc_ends)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #(4_000_000);
    $display("FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (sink_steady) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end
  end

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom); while (b == fqrd_pkg::ChNewline);
    return b;
  endfunction

  // Mostly bases, sometimes any byte that keeps the line open
  function automatic logic [7:0] seq_char();
    string      bases;
    logic [7:0] b;
    bases = "ACGTN";
    if ($urandom_range(0, 9) < 7) begin
      b = bases[$urandom_range(0, 4)];
    end else begin
      do b = 8'($urandom); while (b == fqrd_pkg::ChNewline || b == fqrd_pkg::ChPlus);
    end
    return b;
  endfunction

  // One input transaction, with an optional idle gap ahead of it
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
  endtask

  // End marker; the data byte is ignored, so keep it random
  task automatic end_stream();
    send_item(8'($urandom), 1'b1);
  endtask

  // Byte of a random record, replaced by an end marker at the cut point
  task automatic rec_byte(input logic [7:0] b);
    if (!cut_done) begin
      if (cut_left == 1) begin
        end_stream();
        cut_done = 1'b1;
      end else begin
        if (cut_left > 1) cut_left--;
        send_item(b, 1'b0);
      end
    end
  endtask

  // Well-formed record with random content, sometimes cut short
  task automatic send_record();
    int i;
    int seq_lines;
    int qual_lines;
    bit plus_mid;
    bit open_tail;
    cut_done   = 1'b0;
    cut_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 25) : 0;
    plus_mid   = ($urandom_range(0, 7) == 0);
    open_tail  = ($urandom_range(0, 5) == 0);
    seq_lines  = $urandom_range(0, 4);
    qual_lines = 0;
    rec_byte("@");
    repeat ($urandom_range(0, 10)) rec_byte(any_but_newline());
    rec_byte(fqrd_pkg::ChNewline);
    for (i = 0; i < seq_lines; i++) begin
      repeat ($urandom_range(0, 12)) rec_byte(seq_char());
      // last line may run straight into the plus
      if (!(plus_mid && i == seq_lines - 1)) begin
        rec_byte(fqrd_pkg::ChNewline);
        qual_lines++;
      end
    end
    rec_byte(fqrd_pkg::ChPlus);
    repeat ($urandom_range(0, 5)) rec_byte(any_but_newline());
    rec_byte(fqrd_pkg::ChNewline);
    for (i = 0; i < qual_lines; i++) begin
      repeat ($urandom_range(0, 12)) rec_byte(any_but_newline());
      if (open_tail && i == qual_lines - 1) begin
        if (!cut_done) begin
          end_stream();
          cut_done = 1'b1;
        end
      end else begin
        rec_byte(fqrd_pkg::ChNewline);
      end
    end
  endtask

  // Junk heavy in newlines and plus signs
  task automatic send_noise();
    int         r;
    logic [7:0] b;
    repeat ($urandom_range(4, 20)) begin
      r = $urandom_range(0, 3);
      b = (r == 0) ? fqrd_pkg::ChNewline : (r == 1) ? fqrd_pkg::ChPlus : 8'($urandom);
      send_item(b, 1'b0);
    end
    if ($urandom_range(0, 1) == 0) end_stream();
  endtask

  // Register write once every result is back
  task automatic write_copy_enable(input logic v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_mix(input int quota);
    int goal;
    int pick;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      src_steady  = ($urandom_range(0, 9) == 0);
      sink_steady <= ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) send_record();
      else if (pick < 90) send_noise();
      else end_stream();
    end
    src_steady  = 1'b0;
    sink_steady <= 1'b0;
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, copy_enable still at its reset value
    // no sequence lines: spacer newline closes the record
    send_text("@\n+\n");
    // plus in mid line, spacer text, extreme bytes in header and quality
    send_item("@", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(fqrd_pkg::ChNewline, 1'b0);
    send_text("AC\nG+x\n");
    send_item(8'h00, 1'b0);
    send_item(fqrd_pkg::ChNewline, 1'b0);
    // end between records, ignored byte at its top value
    send_item(8'hFF, 1'b1);
    // end inside a header
    send_item("@", 1'b0);
    send_item(8'h00, 1'b1);
    // last quality line left unterminated
    send_text("@\n\n+\n#");
    end_stream();

    // Random records under both register settings
    write_copy_enable(1'b1);
    run_mix(200);
    write_copy_enable(1'b0);
    run_mix(200);

    // Drain
    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 5000);
    repeat (4) @(posedge clk);

    $display("Checked %0d result transactions: %0d records closed, %0d clean and %0d truncated ends.",
             bytes_checked, records_closed, clean_ends, trunc_ends);
    $display("copy_enable run at both values; records cut short, plus signs mid-line and noise mixed in.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== fastq_record_deframer_unit.f =====
rtl/core/fqrd_pkg.sv
rtl/core/fastq_record_deframer_unit.sv
rtl/core/fqrd_checker.sv
tb/sv/fqrd_record_monitor.sv
tb/sv/tb.sv
